>>> sv/rgb_median_filter_core_assert.svh
`ifndef RGB_MEDIAN_FILTER_CORE_ASSERT_SVH
`define RGB_MEDIAN_FILTER_CORE_ASSERT_SVH

// property that must hold at every edge out of reset
`define RMF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence in the cycle after the antecedent
`define RMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rmf_pkg.sv
package rmf_pkg;

	localparam int PIX_W      = 8;
	localparam int COL_OUT_W  = 10;
	localparam int ROW_W      = 12;
	localparam int RAD_W      = 2;
	localparam int FW_W       = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int COORD_W    = 14;
	localparam int RADE_W     = 3;

	localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
	localparam logic [FW_W-1:0]  WIDTH_RST  = 11'd500;
	localparam logic [ROW_W-1:0] HEIGHT_RST = 12'd500;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SETTLE,
		S_OUT
	} rmf_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} rmf_reg_t;

	typedef struct packed {
		logic clear;
		logic load;
	} rmf_sort_ctl_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	function automatic coord_t clamp_coord(input coord_t v, input coord_t hi);
		coord_t r;
		r = v;
		if (v < 0) r = '0;
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

>>> sv/rmf_pix_if.sv
interface rmf_pix_if import rmf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

>>> sv/rmf_res_if.sv
interface rmf_res_if import rmf_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     red_med;
	logic [PIX_W-1:0]     green_med;
	logic [PIX_W-1:0]     blue_med;
	logic [COL_OUT_W-1:0] out_col;
	logic [ROW_W-1:0]     out_row;
	logic                 burst_last;

	modport source (output valid, red_med, green_med, blue_med, out_col, out_row, burst_last,
		input ready);
	modport sink (input valid, red_med, green_med, blue_med, out_col, out_row, burst_last,
		output ready);
endinterface

>>> sv/rmf_cfg_if.sv
interface rmf_cfg_if import rmf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

>>> sv/rgb_median_filter_core.sv
// channel  role    words
// pix      sink    red_in, green_in, blue_in in raster order
// res      source  per-channel medians with out_col, out_row, burst_last
// cfg      sink    idx 0 radius, 1 frame_width, 2 frame_height; always ready
//
// A pixel with no result due is written to the line store and leaves the core idle.
// Each result takes (2R+1)^2 line store reads (one read port), then the sorting
// chain settles, then the output handshake completes.
// No pixel is taken until every result of the burst is delivered.
// Reset clears the position and restores the register defaults; the line
// store is not cleared, every entry is written before it is read.
module rgb_median_filter_core import rmf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input logic      clk,
	input logic      arst_n,
	rmf_pix_if.sink  pix,
	rmf_res_if.source res,
	rmf_cfg_if.sink  cfg
);
	`include "rgb_median_filter_core_assert.svh"

	localparam int SLOTS = 2 * MAX_RADIUS + 1;
	localparam int NC    = SLOTS * SLOTS;
	localparam int DEPTH = MAX_WIDTH * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int SW    = $clog2(SLOTS);
	localparam int KW    = $clog2(SLOTS);
	localparam int MW    = $clog2(NC);

	rmf_state_t state_q, state_d;

	logic [RAD_W-1:0] radius_q;
	logic [FW_W-1:0]  width_q;
	logic [ROW_W-1:0] height_q;

	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [SW-1:0]    in_slot_q;

	logic [RADE_W-1:0] rad_eff;
	logic [12:0]       w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic              wrap;
	logic [CW-1:0]     c_eff;
	logic [ROW_W-1:0]  r_eff;
	logic [SW-1:0]     slot_eff;

	coord_t c_s, r_s, w_s, h_s, rad_s;
	coord_t x0_c, x1_c, y0_c, y1_c;
	logic   fire_x, fire_y, fire;

	coord_t ox_q, oy_q, x0_q, x1_q, y1_q, cur_row_q;
	logic [SW-1:0] cur_slot_q;
	logic [KW-1:0] kx_q, ky_q, k_max;
	logic [MW:0]   settle_q;
	logic [MW-1:0] mid_idx;
	logic          rd_vld_s1;
	logic          last_now;

	logic accept, start, issue, issue_last, settle_done, take, clear;

	coord_t yy, xx, row_back, slot_s;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [3*PIX_W-1:0] rd_data;

	logic [NC-1:0][PIX_W-1:0] vals_r, vals_g, vals_b;
	rmf_sort_ctl_t sort_ctl;

	logic                 out_vld_q;
	logic [PIX_W-1:0]     red_q, green_q, blue_q;
	logic [COL_OUT_W-1:0] col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 last_q;

	// effective register values
	always_comb begin
		rad_eff = {1'b0, radius_q};
		if (rad_eff > RADE_W'(MAX_RADIUS)) rad_eff = RADE_W'(MAX_RADIUS);
		w_eff = 13'(width_q);
		if (width_q == '0) w_eff = 13'd1;
		else if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	assign wrap     = (13'(in_col_q) >= w_eff) || (in_row_q >= h_eff);
	assign c_eff    = wrap ? '0 : in_col_q;
	assign r_eff    = wrap ? '0 : in_row_q;
	assign slot_eff = wrap ? '0 : in_slot_q;

	assign c_s   = coord_t'(c_eff);
	assign r_s   = coord_t'(r_eff);
	assign w_s   = coord_t'(w_eff);
	assign h_s   = coord_t'(h_eff);
	assign rad_s = coord_t'(rad_eff);

	// output range triggered by this pixel
	always_comb begin
		if (c_s < w_s - 1) begin
			fire_x = (c_s >= rad_s);
			x0_c   = c_s - rad_s;
			x1_c   = c_s - rad_s;
		end else begin
			fire_x = 1'b1;
			x0_c   = (w_s - 1 >= rad_s) ? w_s - 1 - rad_s : '0;
			x1_c   = w_s - 1;
		end
		if (r_s < h_s - 1) begin
			fire_y = (r_s >= rad_s);
			y0_c   = r_s - rad_s;
			y1_c   = r_s - rad_s;
		end else begin
			fire_y = 1'b1;
			y0_c   = (h_s - 1 >= rad_s) ? h_s - 1 - rad_s : '0;
			y1_c   = h_s - 1;
		end
	end
	assign fire = fire_x && fire_y;

	assign k_max    = KW'({rad_eff, 1'b0});
	assign mid_idx  = MW'(2 * int'(rad_eff) * (int'(rad_eff) + 1));
	assign last_now = (ox_q == x1_q) && (oy_q == y1_q);

	always_comb begin
		state_d     = state_q;
		accept      = 1'b0;
		start       = 1'b0;
		issue       = 1'b0;
		issue_last  = 1'b0;
		settle_done = 1'b0;
		take        = 1'b0;
		clear       = 1'b0;
		case (state_q)
			S_IDLE: begin
				accept = pix.valid;
				if (pix.valid && fire) begin
					start   = 1'b1;
					clear   = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				issue = 1'b1;
				if (kx_q == k_max && ky_q == k_max) begin
					issue_last = 1'b1;
					state_d    = S_SETTLE;
				end
			end
			S_SETTLE: begin
				if (settle_q == '0) begin
					settle_done = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_OUT: begin
				if (res.ready) begin
					take = 1'b1;
					if (last_now) state_d = S_IDLE;
					else begin
						clear   = 1'b1;
						state_d = S_READ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// line store addressing: window row is never below the current row by more than 2R
	always_comb begin
		yy       = clamp_coord(oy_q - rad_s + coord_t'(ky_q), h_s - 1);
		xx       = clamp_coord(ox_q - rad_s + coord_t'(kx_q), w_s - 1);
		row_back = cur_row_q - yy;
		slot_s   = coord_t'(cur_slot_q) - row_back;
		if (slot_s < 0) slot_s = slot_s + coord_t'(SLOTS);
	end

	assign rd_addr = AW'(slot_s[SW-1:0]) * AW'(MAX_WIDTH) + AW'(xx);
	assign wr_addr = AW'(slot_eff) * AW'(MAX_WIDTH) + AW'(c_eff);

	rmf_ram #(
		.WIDTH (3 * PIX_W),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept),
		.waddr (wr_addr),
		.wdata ({pix.red_in, pix.green_in, pix.blue_in}),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign sort_ctl.clear = clear;
	assign sort_ctl.load  = rd_vld_s1;

	rmf_sort_chain #(.N(NC)) u_sort_r (
		.clk (clk), .arst_n (arst_n), .ctl (sort_ctl),
		.in_val (rd_data[3*PIX_W-1:2*PIX_W]), .vals (vals_r)
	);
	rmf_sort_chain #(.N(NC)) u_sort_g (
		.clk (clk), .arst_n (arst_n), .ctl (sort_ctl),
		.in_val (rd_data[2*PIX_W-1:PIX_W]), .vals (vals_g)
	);
	rmf_sort_chain #(.N(NC)) u_sort_b (
		.clk (clk), .arst_n (arst_n), .ctl (sort_ctl),
		.in_val (rd_data[PIX_W-1:0]), .vals (vals_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_slot_q <= '0;
			kx_q      <= '0;
			ky_q      <= '0;
			settle_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept) begin
				if (13'(c_eff) + 13'd1 < w_eff) begin
					in_col_q  <= c_eff + CW'(1);
					in_row_q  <= r_eff;
					in_slot_q <= slot_eff;
				end else begin
					in_col_q <= '0;
					if (13'(r_eff) + 13'd1 < 13'(h_eff)) begin
						in_row_q  <= r_eff + ROW_W'(1);
						in_slot_q <= (slot_eff == SW'(SLOTS - 1)) ? '0 : slot_eff + SW'(1);
					end else begin
						in_row_q  <= '0;
						in_slot_q <= '0;
					end
				end
			end
			if (cfg.valid) begin
				case (cfg.idx)
					REG_RADIUS: radius_q <= cfg.data[RAD_W-1:0];
					REG_WIDTH:  width_q  <= cfg.data[FW_W-1:0];
					REG_HEIGHT: height_q <= cfg.data[ROW_W-1:0];
					default: ;
				endcase
				// any listed register restarts the frame
				if (cfg.idx == REG_RADIUS || cfg.idx == REG_WIDTH || cfg.idx == REG_HEIGHT) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					in_slot_q <= '0;
				end
			end
			if (clear) begin
				kx_q <= '0;
				ky_q <= '0;
			end else if (issue) begin
				if (kx_q == k_max) begin
					kx_q <= '0;
					ky_q <= ky_q + KW'(1);
				end else begin
					kx_q <= kx_q + KW'(1);
				end
			end
			if (issue_last) settle_q <= (MW + 1)'(mid_idx) + (MW + 1)'(2);
			else if (settle_q != '0) settle_q <= settle_q - (MW + 1)'(1);
			if (settle_done) out_vld_q <= 1'b1;
			else if (take) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ox_q       <= x0_c;
			oy_q       <= y0_c;
			x0_q       <= x0_c;
			x1_q       <= x1_c;
			y1_q       <= y1_c;
			cur_row_q  <= r_s;
			cur_slot_q <= slot_eff;
		end else if (take && !last_now) begin
			if (ox_q == x1_q) begin
				ox_q <= x0_q;
				oy_q <= oy_q + coord_t'(1);
			end else begin
				ox_q <= ox_q + coord_t'(1);
			end
		end
		if (settle_done) begin
			red_q   <= vals_r[mid_idx];
			green_q <= vals_g[mid_idx];
			blue_q  <= vals_b[mid_idx];
			col_q   <= ox_q[COL_OUT_W-1:0];
			row_q   <= oy_q[ROW_W-1:0];
			last_q  <= last_now;
		end
	end

	assign pix.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign res.valid      = out_vld_q;
	assign res.red_med    = red_q;
	assign res.green_med  = green_q;
	assign res.blue_med   = blue_q;
	assign res.out_col    = col_q;
	assign res.out_row    = row_q;
	assign res.burst_last = last_q;

	`RMF_ASSERT_ALWAYS(a_no_in_while_res, clk, arst_n, !(pix.ready && res.valid), "pixel taken while a result waits")
	`RMF_ASSERT_ALWAYS(a_slot_range, clk, arst_n, in_slot_q < SW'(SLOTS), "line store slot out of range")
	`RMF_ASSERT_NEXT(a_last_idle, clk, arst_n, res.valid && res.ready && res.burst_last, state_q == S_IDLE, "burst did not end")
endmodule

>>> sv/rmf_ram.sv
module rmf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 7168
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

>>> sv/rmf_sort_cell.sv
module rmf_sort_cell import rmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             in_vld,
	input  logic [PIX_W-1:0] in_val,
	output logic             pass_vld,
	output logic [PIX_W-1:0] pass_val,
	output logic [PIX_W-1:0] val
);
	logic             vld_q;
	logic             pass_vld_q;
	logic [PIX_W-1:0] val_q;
	logic [PIX_W-1:0] pass_q;
	logic             lower;

	assign lower = vld_q && (in_val < val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (clear) begin
			vld_q      <= 1'b0;
			pass_vld_q <= 1'b0;
		end else begin
			if (in_vld) vld_q <= 1'b1;
			pass_vld_q <= in_vld && vld_q;
		end
	end

	// keep the smaller word, hand the larger one on
	always_ff @(posedge clk) begin
		if (in_vld) begin
			if (!vld_q || lower) val_q <= in_val;
			pass_q <= lower ? val_q : in_val;
		end
	end

	assign pass_vld = pass_vld_q;
	assign pass_val = pass_q;
	assign val      = val_q;
endmodule

>>> sv/rmf_sort_chain.sv
module rmf_sort_chain import rmf_pkg::*; #(
	parameter int N = 49
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rmf_sort_ctl_t             ctl,
	input  logic [PIX_W-1:0]          in_val,
	output logic [N-1:0][PIX_W-1:0]   vals
);
	logic [N:0]              vld_c;
	logic [N:0][PIX_W-1:0]   val_c;

	assign vld_c[0] = ctl.load;
	assign val_c[0] = in_val;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rmf_sort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (ctl.clear),
			.in_vld   (vld_c[i]),
			.in_val   (val_c[i]),
			.pass_vld (vld_c[i+1]),
			.pass_val (val_c[i+1]),
			.val      (vals[i])
		);
	end
endmodule
